// ===== design/tes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tes_pkg: shared constants for the text encoding sniffer
// Encoding codes, byte order mark bytes and UTF-8 lead byte masks.
// ----------------------------------------------------------------------------
package tes_pkg;

  typedef logic [1:0] kind_t;

  // Encoding verdict codes.
  localparam kind_t KIND_ANSI    = 2'd0;
  localparam kind_t KIND_UTF8    = 2'd1;
  localparam kind_t KIND_UTF16LE = 2'd2;
  localparam kind_t KIND_UTF16BE = 2'd3;

  // Byte order mark bytes and prefixes.
  localparam logic [7:0]  BOM_UTF8_B2   = 8'hBF;
  localparam logic [15:0] BOM_UTF8_PFX  = 16'hEFBB;
  localparam logic [15:0] BOM_UTF16LE   = 16'hFFFE;
  localparam logic [15:0] BOM_UTF16BE   = 16'hFEFF;

  // UTF-8 byte classes: (byte & mask) == pattern.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

endpackage

// ===== design/text_encoding_sniffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_sniffer: byte order mark and UTF-8 scan encoding detector
// Takes a text buffer one byte per item and gives one encoding verdict
// on the item marked last.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, data_byte,            | in
//          | byte_present, is_last                     |
//  result  | out_valid, out_ready, encoding_kind       | out
//
// One item is taken every cycle unless a last item waits in the stage; an item
// passes through an input register and flag update logic, and the verdict lands
// in the result register.
// Reset clears the scan state and both stage valid flags.
// A stalled verdict holds only a staged item marked last; staged items not marked last keep flowing.
//
module text_encoding_sniffer
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_present,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output kind_t      encoding_kind
);

  // Input register.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_present;
  logic       stage_last;

  // Scan state.
  logic [1:0]  byte_position;
  logic [15:0] leading_bytes;
  logic [1:0]  continuations_left;
  logic        invalid_seen;
  logic        multibyte_seen;

  logic [1:0]  byte_position_next;
  logic [15:0] leading_bytes_next;
  logic [1:0]  continuations_left_next;
  logic        invalid_seen_next;
  logic        multibyte_seen_next;
  kind_t       kind_next;

  logic out_busy;
  logic stage_go;

  // Handshake: a last item may only leave the stage when the result slot frees.
  assign out_busy = out_valid && !out_ready;
  assign stage_go = stage_valid && !(stage_last && out_busy);
  assign in_ready = !stage_valid || stage_go;

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_byte    <= data_byte;
      stage_present <= byte_present;
      stage_last    <= is_last;
    end
  end

  // Byte order mark tracking and UTF-8 scan for the staged item.
  always_comb begin
    byte_position_next      = byte_position;
    leading_bytes_next      = leading_bytes;
    continuations_left_next = continuations_left;
    invalid_seen_next       = invalid_seen;
    multibyte_seen_next     = multibyte_seen;
    if (stage_present) begin
      case (byte_position)
        2'd0: begin
          leading_bytes_next = {stage_byte, 8'h00};
          byte_position_next = 2'd1;
        end
        2'd1: begin
          leading_bytes_next = {leading_bytes[15:8], stage_byte};
          byte_position_next = 2'd2;
        end
        2'd2: begin
          if (leading_bytes == BOM_UTF8_PFX && stage_byte != BOM_UTF8_B2) begin
            leading_bytes_next = 16'h0000;
          end
          byte_position_next = 2'd3;
        end
        default: begin
        end
      endcase

      if (!invalid_seen) begin
        if (continuations_left != 2'd0) begin
          if ((stage_byte & CONT_MASK) == CONT_PAT) begin
            continuations_left_next = continuations_left - 2'd1;
            if (continuations_left == 2'd1) begin
              multibyte_seen_next = 1'b1;
            end
          end else begin
            invalid_seen_next = 1'b1;
          end
        end else if (stage_byte < ASCII_TOP) begin
          // Single-byte character leaves the scan unchanged.
        end else if ((stage_byte & LEAD2_MASK) == LEAD2_PAT) begin
          continuations_left_next = 2'd1;
        end else if ((stage_byte & LEAD3_MASK) == LEAD3_PAT) begin
          continuations_left_next = 2'd2;
        end else if ((stage_byte & LEAD4_MASK) == LEAD4_PAT) begin
          continuations_left_next = 2'd3;
        end else begin
          invalid_seen_next = 1'b1;
        end
      end
    end
  end

  // Verdict from the state after the staged byte.
  always_comb begin
    if (byte_position_next == 2'd3 && leading_bytes_next == BOM_UTF8_PFX) begin
      kind_next = KIND_UTF8;
    end else if (byte_position_next[1] && leading_bytes_next == BOM_UTF16LE) begin
      kind_next = KIND_UTF16LE;
    end else if (byte_position_next[1] && leading_bytes_next == BOM_UTF16BE) begin
      kind_next = KIND_UTF16BE;
    end else if (!invalid_seen_next && continuations_left_next == 2'd0 &&
                 multibyte_seen_next) begin
      kind_next = KIND_UTF8;
    end else begin
      kind_next = KIND_ANSI;
    end
  end

  // Scan state update; a last item returns the state to its reset value.
  always_ff @(posedge clk) begin
    if (rst || (stage_go && stage_last)) begin
      byte_position      <= 2'd0;
      leading_bytes      <= 16'h0000;
      continuations_left <= 2'd0;
      invalid_seen       <= 1'b0;
      multibyte_seen     <= 1'b0;
    end else if (stage_go) begin
      byte_position      <= byte_position_next;
      leading_bytes      <= leading_bytes_next;
      continuations_left <= continuations_left_next;
      invalid_seen       <= invalid_seen_next;
      multibyte_seen     <= multibyte_seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && stage_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (stage_go && stage_last) begin
      encoding_kind <= kind_next;
    end
  end

  // With no byte seen, the whole scan state must be clear.
  assert property (@(posedge clk) disable iff (rst)
    byte_position == 2'd0 |-> leading_bytes == 16'h0000 &&
      continuations_left == 2'd0 && !invalid_seen && !multibyte_seen)
    else $error("scan state not clear before first byte");

  // A complete multibyte sequence needs at least two bytes.
  assert property (@(posedge clk) disable iff (rst)
    multibyte_seen |-> byte_position[1])
    else $error("multibyte flag set with fewer than two bytes");

  // A last item leaving the stage yields a verdict and clears the position.
  assert property (@(posedge clk) disable iff (rst)
    stage_go && stage_last |=> out_valid && byte_position == 2'd0)
    else $error("last item did not produce a verdict");

  // A verdict only appears after a last item left the stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_go && stage_last))
    else $error("verdict without a last item");

endmodule
